// File: hdl/pfmw_pkg.sv
// Shared types, codes and the flow ladder for the pulse flow meter window.
package pfmw_pkg;

    localparam int DEF_WINDOW_SLOTS = 10;

    localparam logic [1:0] KIND_PULSE  = 2'd0;
    localparam logic [1:0] KIND_POLL   = 2'd1;
    localparam logic [1:0] KIND_WINDOW = 2'd2;
    localparam logic [1:0] KIND_LOAD   = 2'd3;

    // ladder thresholds, pulses per window
    localparam logic [7:0] FLOW_T1   = 8'd5;
    localparam logic [7:0] FLOW_T2   = 8'd10;
    localparam logic [7:0] FLOW_T3   = 8'd16;
    localparam logic [7:0] FLOW_T4   = 8'd22;
    localparam logic [7:0] FLOW_TOP  = 8'd118;
    localparam logic [4:0] CODE_TOP  = 5'd20;
    // floor(d/6) == (d*43)>>8 for d below 96
    localparam logic [5:0] RECIP6    = 6'd43;

    typedef struct packed {
        logic [1:0]  kind;
        logic        tray_filling;
        logic        pump_on;
        logic [15:0] fill_value;
    } item_t;

    typedef struct packed {
        logic [7:0]  window_sum;
        logic [4:0]  flow_code;
        logic [15:0] fill_remaining_out;
        logic        armed_out;
    } result_t;

    function automatic logic [4:0] flow_ladder(input logic [7:0] hz);
        logic [6:0]  d;
        logic [12:0] p;
        d = 7'(hz - FLOW_T4);
        p = 13'(d * RECIP6);
        if (hz < FLOW_T1)        return 5'd0;
        else if (hz < FLOW_T2)   return 5'd1;
        else if (hz < FLOW_T3)   return 5'd2;
        else if (hz < FLOW_T4)   return 5'd3;
        else if (hz >= FLOW_TOP) return CODE_TOP;
        else                     return 5'(5'd4 + 5'(p[12:8]));
    endfunction

endpackage

// File: hdl/pfmw_window.sv
// Sliding window of slot counts, saturating sum and flow code registers.
module pfmw_window #(
    parameter int WINDOW_SLOTS = pfmw_pkg::DEF_WINDOW_SLOTS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] fresh,
    output logic [7:0] sum_next,
    output logic [4:0] code_next
);
    import pfmw_pkg::*;

    localparam int OLD_SLOTS = WINDOW_SLOTS - 1;
    localparam int SUM_W     = 8 + $clog2(WINDOW_SLOTS);

    logic [7:0]       slots_reg [OLD_SLOTS];
    logic [7:0]       last_sum_reg;
    logic [4:0]       last_code_reg;
    logic [SUM_W-1:0] sum_wide;
    logic [7:0]       sum_sat;

    always_comb
    begin
        sum_wide = SUM_W'(fresh);
        for (int i = 0; i < OLD_SLOTS; i++)
        begin
            sum_wide = sum_wide + SUM_W'(slots_reg[i]);
        end
        sum_sat = (sum_wide > SUM_W'(8'hFF)) ? 8'hFF : sum_wide[7:0];
    end

    assign sum_next  = push ? sum_sat : last_sum_reg;
    assign code_next = push ? flow_ladder(sum_sat) : last_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sum_reg  <= '0;
            last_code_reg <= '0;
            for (int i = 0; i < OLD_SLOTS; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            last_sum_reg  <= sum_next;
            last_code_reg <= code_next;
            slots_reg[0]  <= fresh;
            for (int i = 1; i < OLD_SLOTS; i++)
            begin
                slots_reg[i] <= slots_reg[i-1];
            end
        end
    end

endmodule

// File: hdl/pfmw_out_buf.sv
// Result register with a skid stage that holds one more result under a stall.
module pfmw_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    output logic              load_ready,
    input  pfmw_pkg::result_t load_data,
    output logic              valid,
    input  logic              ready,
    output pfmw_pkg::result_t data
);
    import pfmw_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;

    assign load_ready = !skid_valid_reg;
    assign valid      = main_valid_reg;
    assign data       = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || ready)
        begin
            main_valid_reg <= skid_valid_reg || load_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (load_valid && load_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || ready)
        begin
            main_reg <= skid_valid_reg ? skid_reg : load_data;
        end
        else if (load_valid && load_ready)
        begin
            skid_reg <= load_data;
        end
    end

endmodule

// File: hdl/pulse_flow_meter_window_core.sv
// Flow sensor front end: pulse gating, fill budget, sliding window and flow code.
// Each accepted item beat yields one result beat from the registered output buffer.
// Throughput: one item per cycle while the skid register is empty; state
// updates in the accept cycle, and a two-deep result buffer (output register
// plus skid) takes one result while the result side stalls, then drops item_ready.
// Reset (rst_n, async, active low): armed, no latched pulse, zero count,
// window, sum, code and fill budget; the result buffer is emptied.
module pulse_flow_meter_window_core #(
    parameter int WINDOW_SLOTS = pfmw_pkg::DEF_WINDOW_SLOTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pfmw_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output pfmw_pkg::result_t result
);
    import pfmw_pkg::*;

    // control state
    logic        armed_reg,   armed_next;
    logic        latched_reg, latched_next;
    logic [7:0]  count_reg,   count_next;
    logic [15:0] fill_reg,    fill_next;

    logic        take;       // item beat accepted this cycle
    logic        push;       // window tick accepted
    logic [7:0]  sum_next;
    logic [4:0]  code_next;
    result_t     res;

    assign take = item_valid && item_ready;
    assign push = take && (item.kind == KIND_WINDOW);

    always_comb
    begin
        armed_next   = armed_reg;
        latched_next = latched_reg;
        count_next   = count_reg;
        fill_next    = fill_reg;
        if (take)
        begin
            case (item.kind)
                KIND_PULSE:
                begin
                    // disarmed pulses are dropped
                    if (armed_reg)
                    begin
                        latched_next = 1'b1;
                        armed_next   = 1'b0;
                        if (item.tray_filling && item.pump_on && (fill_reg != '0))
                        begin
                            fill_next = fill_reg - 16'd1;
                        end
                    end
                end
                KIND_POLL:
                begin
                    if (latched_reg)
                    begin
                        latched_next = 1'b0;
                        count_next   = count_reg + 8'd1;  // wraps mod 256
                        armed_next   = 1'b1;
                    end
                end
                KIND_WINDOW:
                begin
                    count_next = '0;
                end
                KIND_LOAD:
                begin
                    fill_next = item.fill_value;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b1;
            latched_reg <= 1'b0;
            count_reg   <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            armed_reg   <= armed_next;
            latched_reg <= latched_next;
            count_reg   <= count_next;
            fill_reg    <= fill_next;
        end
    end

    // window shift line, saturating sum and ladder
    pfmw_window #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .fresh    (count_reg),
        .sum_next (sum_next),
        .code_next(code_next)
    );

    // every result carries the latest sum and code, also for non-window beats
    always_comb
    begin
        res.window_sum         = sum_next;
        res.flow_code          = code_next;
        res.fill_remaining_out = fill_next;
        res.armed_out          = armed_next;
    end

    pfmw_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_valid(take),
        .load_ready(item_ready),
        .load_data (res),
        .valid     (result_valid),
        .ready     (result_ready),
        .data      (result)
    );

endmodule

// File: verif/pfmw_checker.sv
// Checker for the pulse flow meter window core: predicts each result beat and compares it.
module pfmw_checker #(
    parameter int WINDOW_SLOTS = pfmw_pkg::DEF_WINDOW_SLOTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  pfmw_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  pfmw_pkg::result_t result,
    output int                mismatch_count,
    output int                readings_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import pfmw_pkg::*;

    localparam int CODE_STEP = 6;
    localparam int SUM_MAX   = 255;

    // predicted meter state
    logic        armed_q;
    logic        latched_q;
    logic [7:0]  count_q;
    logic [7:0]  history_q [WINDOW_SLOTS-1];
    logic [7:0]  sum_q;
    logic [4:0]  code_q;
    logic [15:0] budget_q;

    result_t expected_readings [$];

    initial
    begin
        mismatch_count = 0;
        readings_due   = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [4:0] rate_to_code(input logic [7:0] hz);
        if (hz < FLOW_T1)
            return 5'd0;
        else if (hz < FLOW_T2)
            return 5'd1;
        else if (hz < FLOW_T3)
            return 5'd2;
        else if (hz < FLOW_T4)
            return 5'd3;
        else if (hz >= FLOW_TOP)
            return CODE_TOP;
        else
            return 5'(4 + (int'(hz) - int'(FLOW_T4)) / CODE_STEP);
    endfunction

    // advances the predicted state by one item and returns the reading it shows
    function automatic result_t step_meter(input item_t it);
        int      total;
        result_t r;
        case (it.kind)
            KIND_PULSE:
            begin
                if (armed_q)
                begin
                    latched_q = 1'b1;
                    if (it.tray_filling && it.pump_on && budget_q != 16'd0)
                        budget_q = budget_q - 16'd1;
                    armed_q = 1'b0;
                end
            end
            KIND_POLL:
            begin
                if (latched_q)
                begin
                    latched_q = 1'b0;
                    count_q   = count_q + 8'd1;
                    armed_q   = 1'b1;
                end
            end
            KIND_WINDOW:
            begin
                total = count_q;
                for (int i = 0; i < WINDOW_SLOTS - 1; i++)
                    total += history_q[i];
                if (total > SUM_MAX)
                    total = SUM_MAX;
                for (int i = WINDOW_SLOTS - 2; i > 0; i--)
                    history_q[i] = history_q[i-1];
                history_q[0] = count_q;
                count_q      = 8'd0;
                sum_q        = 8'(total);
                code_q       = rate_to_code(sum_q);
            end
            default:
                budget_q = it.fill_value;
        endcase
        r.window_sum         = sum_q;
        r.flow_code          = code_q;
        r.fill_remaining_out = budget_q;
        r.armed_out          = armed_q;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            armed_q   = 1'b1;
            latched_q = 1'b0;
            count_q   = 8'd0;
            for (int i = 0; i < WINDOW_SLOTS - 1; i++)
                history_q[i] = 8'd0;
            sum_q     = 8'd0;
            code_q    = 5'd0;
            budget_q  = 16'd0;
            expected_readings.delete();
        end
        else
        begin
            // result first: a beat leaving now belongs to an earlier item
            if (result_valid && result_ready)
            begin
                if (expected_readings.size() == 0)
                    report_mismatch("result beat with no item pending");
                else
                begin
                    want = expected_readings.pop_front();
                    if (result.window_sum !== want.window_sum)
                        report_mismatch($sformatf("window_sum got %0d expected %0d",
                                                  result.window_sum, want.window_sum));
                    if (result.flow_code !== want.flow_code)
                        report_mismatch($sformatf("flow_code got %0d expected %0d",
                                                  result.flow_code, want.flow_code));
                    if (result.fill_remaining_out !== want.fill_remaining_out)
                        report_mismatch($sformatf("fill_remaining_out got %0d expected %0d",
                                                  result.fill_remaining_out,
                                                  want.fill_remaining_out));
                    if (result.armed_out !== want.armed_out)
                        report_mismatch($sformatf("armed_out got %0b expected %0b",
                                                  result.armed_out, want.armed_out));
                end
            end
            if (item_valid && item_ready)
                expected_readings.push_back(step_meter(item));
        end
        readings_due = expected_readings.size();
    end

endmodule

// File: verif/tb_pulse_flow_meter_window_core.sv
// Testbench top for the pulse flow meter window core: stimulus, flow control and verdict.
module tb_pulse_flow_meter_window_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pfmw_pkg::*;

    localparam int WINDOW_SLOTS = DEF_WINDOW_SLOTS;
    // cycles in a row with no beat on either channel before the run is called hung
    localparam int STALL_LIMIT  = 2000;
    // random beats per flow-control phase, long bursts not included
    localparam int PHASE_BEATS  = 110;
    // pulse/poll pairs in the long count burst that opens a phase
    localparam int LONG_PAIRS   = 20;
    localparam int DRAIN_CYCLES = 8;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    item_t   item         = '0;
    logic    item_ready;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    int send_idle_pct  = 0;
    int take_idle_pct  = 0;
    int stall_cycles   = 0;
    int mismatch_count;
    int readings_due;

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pulse_flow_meter_window_core #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    pfmw_checker #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .mismatch_count (mismatch_count),
        .readings_due   (readings_due)
    );

    // Result side: ready is redrawn every falling edge, so stalls land on any
    // cycle of the core's work, including the one right after an item beat.
    always @(negedge clk)
        result_ready <= ($urandom_range(0, 99) >= take_idle_pct);

    // Watchdog: any beat on either channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // One item beat. Gaps are drawn before the beat; valid then holds with a
    // stable payload until the edge that takes it. Valid is left high on return
    // so back-to-back beats never drop it in between.
    task automatic send_beat(input logic [1:0] kind, input logic fill, input logic pump,
                             input logic [15:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid         <= 1'b1;
        item.kind          <= kind;
        item.tray_filling  <= fill;
        item.pump_on       <= pump;
        item.fill_value    <= value;
        do
            @(posedge clk);
        while (!(item_valid && item_ready));
    endtask

    // beat of a given kind with every other field random
    task automatic send_kind(input logic [1:0] kind);
        send_beat(kind, 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    // Well-formed counting: pulses and polls alternate, so each poll turns a
    // latched pulse into one count. Filling with the pump on is favored so the
    // budget keeps moving.
    task automatic pulse_poll_burst(input int pairs);
        logic both;
        for (int n = 0; n < pairs; n++)
        begin
            both = ($urandom_range(0, 99) < 60);
            send_beat(KIND_PULSE, both | 1'($urandom), both | 1'($urandom), 16'($urandom));
            send_kind(KIND_POLL);
        end
    endtask

    // One flow-control phase. A nonzero long_pairs first runs one long count
    // burst, closes the window on it, then adds a short window on top so the
    // sum climbs high on the ladder.
    task automatic run_phase(input int send_pct, input int take_pct, input int long_pairs);
        int phase_end;
        int pick;
        send_idle_pct = send_pct;
        take_idle_pct = take_pct;
        if (long_pairs > 0)
        begin
            pulse_poll_burst(long_pairs);
            send_kind(KIND_WINDOW);
            pulse_poll_burst($urandom_range(1, 20));
            send_kind(KIND_WINDOW);
        end
        phase_end = PHASE_BEATS;
        while (phase_end > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // mostly low rates so the whole ladder is visited, some high ones
                if ($urandom_range(0, 3) == 0)
                    pick = $urandom_range(0, 40);
                else
                    pick = $urandom_range(0, 10);
                pulse_poll_burst(pick);
                send_kind(KIND_WINDOW);
                phase_end -= 2 * pick + 1;
            end
            else if (pick < 70)
            begin
                // noise: anything at all, including pulses while disarmed
                pick = $urandom_range(1, 8);
                repeat (pick)
                    send_kind(2'($urandom_range(0, 3)));
                phase_end -= pick;
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 9) < 3)
                    send_beat(KIND_LOAD, 1'($urandom), 1'($urandom),
                              16'($urandom_range(0, 3)));
                else
                    send_kind(KIND_LOAD);
                phase_end -= 1;
            end
            else if (pick < 90)
            begin
                // broken pairing: second pulse is ignored, second poll finds nothing
                send_kind(KIND_PULSE);
                send_kind(KIND_PULSE);
                send_kind(KIND_POLL);
                send_kind(KIND_POLL);
                send_kind(KIND_WINDOW);
                phase_end -= 5;
            end
            else
            begin
                // small budget counted down by pulses, often to zero and past it
                send_beat(KIND_LOAD, 1'($urandom), 1'($urandom), 16'($urandom_range(1, 4)));
                pick = $urandom_range(3, 7);
                repeat (pick)
                begin
                    send_beat(KIND_PULSE, 1'b1, 1'b1, 16'($urandom));
                    send_kind(KIND_POLL);
                end
                phase_end -= 2 * pick + 1;
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 33;
        take_idle_pct = 72;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- directed part ---
        send_beat(KIND_POLL,   1'b0, 1'b0, 16'h0000);   // poll with nothing latched
        send_beat(KIND_WINDOW, 1'b1, 1'b1, 16'hFFFF);   // empty window: sum 0, code 0
        send_beat(KIND_LOAD,   1'b0, 1'b0, 16'hFFFF);   // largest budget
        send_beat(KIND_PULSE,  1'b1, 1'b1, 16'h0000);   // counts the budget down, disarms
        send_beat(KIND_PULSE,  1'b1, 1'b1, 16'hFFFF);   // disarmed: ignored
        send_beat(KIND_POLL,   1'b1, 1'b1, 16'h0000);   // one count, re-arms
        send_beat(KIND_PULSE,  1'b1, 1'b0, 16'h0000);   // filling, pump off
        send_beat(KIND_POLL,   1'b0, 1'b0, 16'h0000);
        send_beat(KIND_PULSE,  1'b0, 1'b1, 16'h0000);   // pump on, not filling
        send_beat(KIND_POLL,   1'b0, 1'b0, 16'h0000);
        send_beat(KIND_WINDOW, 1'b0, 1'b0, 16'h0000);   // sum 3
        send_beat(KIND_LOAD,   1'b1, 1'b1, 16'h0001);
        send_beat(KIND_PULSE,  1'b1, 1'b1, 16'h0000);   // budget to zero
        send_beat(KIND_POLL,   1'b0, 1'b0, 16'h0000);
        send_beat(KIND_PULSE,  1'b1, 1'b1, 16'h0000);   // budget stays at zero
        send_beat(KIND_POLL,   1'b0, 1'b0, 16'h0000);
        send_beat(KIND_LOAD,   1'b0, 1'b0, 16'h0000);   // smallest load
        send_beat(KIND_WINDOW, 1'b0, 1'b0, 16'h0000);   // sum 5: first ladder step
        send_beat(KIND_LOAD,   1'b1, 1'b0, 16'hA5A5);
        send_beat(KIND_LOAD,   1'b0, 1'b1, 16'h5A5A);

        // --- random part, three flow-control phases ---
        run_phase(33, 72, LONG_PAIRS);
        run_phase(72, 33, 0);
        run_phase(0, 0, LONG_PAIRS + $urandom_range(0, 20));

        @(negedge clk);
        item_valid <= 1'b0;

        // drain; the watchdog covers a result that never shows up
        while (readings_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
